>>> hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes, state and operation codes, and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    localparam int WIDTH   = 32;
    localparam int DATA_W  = ((WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WIDTH);
    localparam int INDEX_W = 2;

    typedef enum logic [INDEX_W-1:0] {
        REG_MODULUS  = 2'd0,
        REG_EXPONENT = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } state_t;

    // Which modular product the shared multiplier forms and where it goes.
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC,
        OP_SQ
    } op_t;

    typedef struct packed {
        logic accept;
        logic start;
        op_t  op;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic exp_cfg_zero;
        logic mul_last;
        logic e_bit0;
        logic e_rest_zero;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/mexp_dp.sv
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Configuration registers, the running power and square, the exponent
// shifter, a bit-serial modular multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp
    import mexp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic [DATA_W-1:0] s_tdata,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [DATA_W-1:0]      m_tdata,
    input  wire cmd_t              cmd,
    output status_t                status
);

    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [WIDTH-1:0] e_reg;
    logic             ezero_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] sq_reg;
    logic [WIDTH-1:0] mul_a_reg;
    logic [WIDTH-1:0] mul_b_reg;
    logic [WIDTH-1:0] mul_acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    op_t              op_reg;
    logic [WIDTH-1:0] out_reg;
    logic             out_valid_reg;

    logic [WIDTH-1:0] cfg_value;
    logic [WIDTH-1:0] one_mod;
    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] n1;
    logic [WIDTH+1:0] n2;
    logic [WIDTH-1:0] red;

    assign cfg_value = cfg_data[WIDTH-1:0];
    assign one_mod   = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    // One multiplier step: double the partial product and add the operand
    // when the top bit of the multiplier is set. Both terms are below n, so
    // the sum stays below 3n and at most two subtractions of n reduce it.
    assign n1  = {2'b00, mod_reg};
    assign n2  = {1'b0, mod_reg, 1'b0};
    assign sum = {1'b0, mul_acc_reg, 1'b0}
                 + (mul_b_reg[WIDTH-1] ? {2'b00, mul_a_reg} : '0);

    always_comb begin
        priority if (sum >= n2) begin
            red = WIDTH'(sum - n2);
        end else if (sum >= n1) begin
            red = WIDTH'(sum - n1);
        end else begin
            red = sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= WIDTH'(1);
            exp_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MODULUS && cfg_value != '0) begin
                mod_reg <= cfg_value;
            end
            if (cfg_index == REG_EXPONENT) begin
                exp_reg <= cfg_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            e_reg     <= exp_reg;
            ezero_reg <= (exp_reg == '0);
            acc_reg   <= one_mod;
        end
        if (cmd.accept) begin
            mul_a_reg <= one_mod;
            mul_b_reg <= s_tdata[WIDTH-1:0];
        end else if (cmd.start) begin
            mul_a_reg <= sq_reg;
            mul_b_reg <= (cmd.op == OP_ACC) ? acc_reg : sq_reg;
        end else if (cmd.step) begin
            mul_b_reg <= {mul_b_reg[WIDTH-2:0], 1'b0};
        end
        if (cmd.start) begin
            mul_acc_reg <= '0;
            cnt_reg     <= '0;
            op_reg      <= cmd.op;
        end else if (cmd.step) begin
            mul_acc_reg <= red;
            cnt_reg     <= cnt_reg + CNT_W'(1);
            if (status.mul_last) begin
                unique case (op_reg)
                    OP_REDUCE: sq_reg  <= red;
                    OP_ACC:    acc_reg <= red;
                    OP_SQ: begin
                        sq_reg <= red;
                        e_reg  <= e_reg >> 1;
                    end
                    default: sq_reg <= red;
                endcase
            end
        end
        if (cmd.emit) begin
            out_reg <= ezero_reg ? WIDTH'(1) : acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_reg);

    assign status.exp_cfg_zero = (exp_reg == '0);
    assign status.mul_last     = (cnt_reg == CNT_W'(WIDTH - 1));
    assign status.e_bit0       = e_reg[0];
    assign status.e_rest_zero  = (e_reg[WIDTH-1:1] == '0);
    assign status.out_busy     = out_valid_reg && !m_tready;

endmodule

`default_nettype wire

>>> hdl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences the base reduction and the multiply and square passes over the
// exponent bits, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accd_reg;
    logic   accd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            accd_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            accd_reg  <= accd_next;
        end
    end

    // The flag records that the multiply for the current exponent bit is done.
    always_comb begin
        state_next = state_reg;
        accd_next  = accd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                accd_next = 1'b0;
                if (s_tvalid) begin
                    state_next = status.exp_cfg_zero ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                if (status.mul_last) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                priority if (!accd_reg && status.e_bit0) begin
                    accd_next  = 1'b1;
                    state_next = ST_MUL;
                end else if (status.e_rest_zero) begin
                    state_next = ST_DONE;
                end else begin
                    accd_next  = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.op   = OP_REDUCE;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                cmd.start  = s_tvalid && !status.exp_cfg_zero;
            end
            ST_MUL: begin
                cmd.step = 1'b1;
            end
            ST_STEP: begin
                priority if (!accd_reg && status.e_bit0) begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_ACC;
                end else if (!status.e_rest_zero) begin
                    cmd.start = 1'b1;
                    cmd.op    = OP_SQ;
                end else begin
                    cmd.start = 1'b0;
                end
            end
            ST_DONE: begin
                cmd.emit = !status.out_busy;
            end
            default: cmd.start = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Raises each base item to the configured exponent modulo the configured
// modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Content
// s_       in         tdata[31:0] base
// m_       out        tdata[31:0] power
// cfg_     in         index 0 modulus (zero ignored), index 1 exponent
//
// One item first reduces the base, then makes one multiplier pass for every
// multiply and every square; a zero exponent skips every pass. The modular
// multiplier is bit-serial, one multiplier bit per cycle. Reset gives
// modulus 1 and exponent 0. A result waits in the output register while the
// next item is taken; the block stalls only when it finishes with that
// register still full.
//
`default_nettype none

module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,     // [31:0] base
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [DATA_W-1:0]       m_tdata,     // [31:0] power
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mexp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
